FILE: rtl/piecewise_linear_tone_map_top_macros.svh
`ifndef PIECEWISE_LINEAR_TONE_MAP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_TONE_MAP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plm assertion failed");

// next-cycle implication, checked outside reset
`define PLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plm assertion failed");

`endif

FILE: rtl/plm_pkg.sv
`timescale 1ns / 1ps
package plm_pkg;
    localparam int MAX_POINTS_DEF = 7;
    localparam int NUM_POINT_REGS = 7;
    localparam int LEVELS         = 256;
    localparam int PIX_W          = 8;
    localparam int ADDR_W         = $clog2(LEVELS);
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 16;
    localparam int NUMP_W         = 3;
    localparam int DIV_N_W        = 2 * PIX_W;
    localparam int DIV_CNT_W      = $clog2(DIV_N_W);

    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_A    = 4'd1;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_lut_wr;
endpackage

FILE: rtl/plm_lut.sv
`timescale 1ns / 1ps
module plm_lut import plm_pkg::*; (
    input  logic              i_clk,
    input  t_lut_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [PIX_W-1:0]  o_rd_data
);
    logic [PIX_W-1:0] r_mem [LEVELS];
    logic [PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: rtl/plm_div.sv
`timescale 1ns / 1ps
module plm_div import plm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [PIX_W-1:0]   i_den,
    output logic               o_done,
    output logic [PIX_W-1:0]   o_quo
);
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_num;
    logic [DIV_N_W-1:0]   r_quo;
    logic [PIX_W-1:0]     r_rem;
    logic [PIX_W-1:0]     r_den;
    logic [PIX_W:0]       n_trial;
    logic                 n_ge;

    always_comb begin
        n_trial = {r_rem, r_num[DIV_N_W-1]};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_N_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_N_W-2:0], n_ge};
            r_rem <= n_ge ? PIX_W'(n_trial - {1'b0, r_den}) : PIX_W'(n_trial);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[PIX_W-1:0];
endmodule

FILE: rtl/plm_build.sv
`timescale 1ns / 1ps
module plm_build import plm_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_restart,
    input  logic [NUMP_W-1:0]                  i_num_points,
    input  t_point [NUM_POINT_REGS-1:0]        i_points,
    output logic                               o_busy,
    output t_lut_wr                            o_wr
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int QN = MAX_POINTS - 1;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SORT, S_SEG, S_DIV} t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_n;
    logic [CW-1:0]          r_len;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          r_oi;
    t_point                 r_cur;
    t_point [QN-1:0]        r_q;
    t_point [MAX_POINTS-1:0] r_srt;
    logic [PIX_W-1:0]       r_v;
    logic [PIX_W-1:0]       r_y1;
    logic                   r_neg;
    logic [DIV_N_W-1:0]     r_prod;
    logic [PIX_W-1:0]       r_dx;
    logic                   r_div_start;
    t_lut_wr                r_wr;

    logic [CW-1:0]          n_used;
    t_point                 n_head;
    logic                   n_swap;
    t_point                 n_keep;
    t_point                 n_last;
    logic                   n_below;
    logic                   n_above;
    logic [PIX_W-1:0]       n_x1;
    logic [PIX_W-1:0]       n_y1;
    logic [PIX_W-1:0]       n_x2;
    logic [PIX_W-1:0]       n_y2;
    logic                   n_neg;
    logic [PIX_W-1:0]       n_ady;
    logic [PIX_W-1:0]       n_dvx;
    logic                   div_done;
    logic [PIX_W-1:0]       div_quo;
    logic [PIX_W-1:0]       n_val;

    always_comb begin
        if (i_num_points < NUMP_W'(2)) begin
            n_used = CW'(2);
        end else if (int'(i_num_points) > MAX_POINTS) begin
            n_used = CW'(MAX_POINTS);
        end else begin
            n_used = CW'(i_num_points);
        end
    end

    always_comb begin
        n_head = r_q[0];
        n_swap = (r_cur.x > n_head.x);
        n_keep = n_swap ? r_cur : n_head;
    end

    // segment lookup over the sorted breakpoints
    always_comb begin
        n_last = r_srt[0];
        n_x1   = '0;
        n_y1   = '0;
        n_x2   = '0;
        n_y2   = '0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (CW'(k) == r_n - 1'b1) begin
                n_last = r_srt[k];
            end
        end
        for (int k = 0; k < MAX_POINTS - 1; k++) begin
            if ((CW'(k + 1) < r_n) && (r_srt[k].x <= r_v) && (r_v < r_srt[k+1].x)) begin
                n_x1 = n_x1 | r_srt[k].x;
                n_y1 = n_y1 | r_srt[k].y;
                n_x2 = n_x2 | r_srt[k+1].x;
                n_y2 = n_y2 | r_srt[k+1].y;
            end
        end
        n_below = (r_v < r_srt[0].x);
        n_above = (r_v >= n_last.x);
        n_neg   = (n_y2 < n_y1);
        n_ady   = n_neg ? (n_y1 - n_y2) : (n_y2 - n_y1);
        n_dvx   = r_v - n_x1;
        n_val   = r_y1 + (r_neg ? (~div_quo + 1'b1) : div_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_div_start <= 1'b0;
            r_wr.we     <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_wr.we     <= 1'b0;
            if (i_restart) begin
                r_state <= S_LOAD;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        r_state <= S_IDLE;
                    end
                    S_LOAD: begin
                        r_cur <= i_points[0];
                        for (int k = 0; k < QN; k++) begin
                            r_q[k] <= i_points[k+1];
                        end
                        r_n     <= n_used;
                        r_len   <= n_used - 1'b1;
                        r_cnt   <= n_used - 1'b1;
                        r_oi    <= '0;
                        r_state <= S_SORT;
                    end
                    S_SORT: begin
                        for (int k = 0; k < QN - 1; k++) begin
                            r_q[k] <= r_q[k+1];
                        end
                        if (r_cnt != '0) begin
                            for (int k = 0; k < QN; k++) begin
                                if (CW'(k) == r_len - 1'b1) begin
                                    r_q[k] <= n_keep;
                                end
                            end
                            r_cur <= n_swap ? n_head : r_cur;
                            r_cnt <= r_cnt - 1'b1;
                        end else begin
                            for (int k = 0; k < MAX_POINTS; k++) begin
                                if (CW'(k) == r_oi) begin
                                    r_srt[k] <= r_cur;
                                end
                            end
                            r_oi <= r_oi + 1'b1;
                            if (r_len == '0) begin
                                r_v     <= '0;
                                r_state <= S_SEG;
                            end else begin
                                r_cur <= n_head;
                                r_len <= r_len - 1'b1;
                                r_cnt <= r_len - 1'b1;
                            end
                        end
                    end
                    S_SEG: begin
                        if (n_below || n_above) begin
                            r_wr.we   <= 1'b1;
                            r_wr.addr <= r_v;
                            r_wr.data <= n_below ? r_srt[0].y : n_last.y;
                            r_v       <= r_v + 1'b1;
                            if (r_v == PIX_W'(LEVELS - 1)) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_prod      <= n_ady * n_dvx;
                            r_dx        <= n_x2 - n_x1;
                            r_y1        <= n_y1;
                            r_neg       <= n_neg;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                    S_DIV: begin
                        // a done pulse in the start cycle belongs to an aborted division
                        if (div_done && !r_div_start) begin
                            r_wr.we   <= 1'b1;
                            r_wr.addr <= r_v;
                            r_wr.data <= n_val;
                            r_v       <= r_v + 1'b1;
                            r_state   <= (r_v == PIX_W'(LEVELS - 1)) ? S_IDLE : S_SEG;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    plm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_prod),
        .i_den   (r_dx),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // busy until the last curve write has reached the memory
    assign o_busy = (r_state != S_IDLE) || r_wr.we;
    assign o_wr   = r_wr;
endmodule

FILE: rtl/piecewise_linear_tone_map_top.sv
`timescale 1ns / 1ps
// Piecewise-linear tone map: each 8-bit pixel is looked up in a 256-entry curve memory that
// the block fills itself after reset and after every configuration write. The fill sorts the
// breakpoints, then writes one level per cycle on flat ends of the curve and, inside a sloped
// segment, one level per division of a bit-serial divider that forms the quotient; during the
// fill o_in_ready is low. Once filled, one pixel is accepted every clock while the output is
// not stalled; the result passes through the registered read of the curve memory and the
// output register.
module piecewise_linear_tone_map_top import plm_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [NUMP_W-1:0]           r_num_points;
    t_point [NUM_POINT_REGS-1:0] r_pts;
    logic                        r_v1;
    logic                        r_out_valid;
    logic [PIX_W-1:0]            r_out_data;
    logic                        cfg_acc;
    logic                        in_acc;
    logic                        adv;
    logic                        busy;
    t_lut_wr                     lut_wr;
    logic [PIX_W-1:0]            rd_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = !busy && !i_cfg_valid && (!r_v1 || adv);
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= NUMP_W'(2);
            for (int k = 0; k < NUM_POINT_REGS; k++) begin
                r_pts[k] <= '0;
            end
            r_pts[1] <= '1;
        end else if (cfg_acc) begin
            if (i_cfg_index == REG_NUM_POINTS) begin
                r_num_points <= i_cfg_data[NUMP_W-1:0];
            end
            for (int k = 0; k < NUM_POINT_REGS; k++) begin
                if (i_cfg_index == REG_POINT_A + CFG_IDX_W'(k)) begin
                    r_pts[k] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_v1 <= 1'b1;
            end else if (adv) begin
                r_v1 <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_v1) begin
            r_out_data <= rd_data;
        end
    end

    plm_build #(.MAX_POINTS(MAX_POINTS)) u_build (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (cfg_acc),
        .i_num_points (r_num_points),
        .i_points     (r_pts),
        .o_busy       (busy),
        .o_wr         (lut_wr)
    );

    plm_lut u_lut (
        .i_clk     (i_clk),
        .i_wr      (lut_wr),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_pixel_in),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_data;
endmodule

FILE: rtl/plm_chk.sv
`timescale 1ns / 1ps
`include "piecewise_linear_tone_map_top_macros.svh"
module plm_chk import plm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [PIX_W-1:0]      i_pixel_in,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [PIX_W-1:0]      o_pixel_out,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);
    `PLM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `PLM_ASSERT_NOW(a_no_pixel_on_cfg, i_cfg_valid, !o_in_ready)
    `PLM_ASSERT_NEXT(a_refill_after_cfg, i_cfg_valid && o_cfg_ready, !o_in_ready)
endmodule

bind piecewise_linear_tone_map_top plm_chk u_chk (.*);
